>>> rtl/tccw_pkg.sv
// Shared constants for the text console cell writer: op codes, register indexes and reset values.
package tccw_pkg;

   // Op codes carried in the req_op field.
   localparam logic [2:0] OP_PUT   = 3'd0;
   localparam logic [2:0] OP_LINE  = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_MARK  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 2'd1;

   // Field widths fixed by the interface.
   localparam int unsigned CHAR_W     = 16;
   localparam int unsigned ROWS_CFG_W = 6;
   localparam int unsigned COLS_CFG_W = 7;
   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned OUT_ROW_W  = 5;
   localparam int unsigned CURSOR_COL_W = 7;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 16'd10;
   localparam logic [CHAR_W-1:0] NUL_CODE     = 16'd0;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET    = 6'd32;
   localparam logic [COLS_CFG_W-1:0] COLUMNS_RESET = 7'd127;

   // Default geometry of the cell store.
   localparam int unsigned DEFAULT_MAX_ROWS  = 32;
   localparam int unsigned DEFAULT_ROW_CELLS = 128;

endpackage

>>> rtl/text_console_cell_writer.sv
// Text console cell writer: a cell store with a cursor writing into a ring of rows.
//
// Usage. Items enter on the req_ channel (valid/stall) and carry an op, a character
// code and a cell address for reads. Each accepted item gives exactly one item on
// the rsp_ channel: the cell contents for a read (zero for other ops) and the
// cursor position after the op. Configuration (rows in the ring, columns per row)
// is written through the csr_ port; the user must write it only while the block is
// idle, which the block does not enforce; such a write takes effect on the next item.
//
// Sequencing. One item is worked on at a time. A put passes through the execute, put and done
// states, a read through execute, read and done; a mark, a clear or an unknown op goes from
// execute straight to done. The done state loads the output register; the next item is taken
// once the block is idle again. A row advance adds the advance state, and the modulo state when
// row + 1 is not below the row count, as a one-bit-per-cycle remainder unit takes the modulo.
// Row clears cost no memory sweep: a per-row fill count hides stale cells.
//
// Reset is synchronous and active high. It zeroes the cursor and every fill count, so
// the store reads as zero at once with no clearing pass; req_stall is high during reset.
// A result waits in the output register while the receiver stalls; the next item is
// still taken, and its result is held until the output register is free.
module text_console_cell_writer
   import tccw_pkg::*;
#(
   parameter int unsigned MAX_ROWS  = DEFAULT_MAX_ROWS,
   parameter int unsigned ROW_CELLS = DEFAULT_ROW_CELLS
) (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration port.
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_op,
   input  logic [CHAR_W-1:0]       req_char_code,
   input  logic [4:0]              req_read_row,
   input  logic [6:0]              req_read_column,
   // Response channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHAR_W-1:0]       rsp_read_char,
   output logic [OUT_ROW_W-1:0]    rsp_cursor_row,
   output logic [CURSOR_COL_W-1:0] rsp_cursor_column
);

   localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned COL_W = $clog2(ROW_CELLS);
   localparam int unsigned FILL_W = $clog2(ROW_CELLS + 1);
   localparam int unsigned NUM_W = $clog2(MAX_ROWS + 1);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);
   localparam int unsigned ADDR_W = ROW_W + COL_W;
   localparam int unsigned DEPTH = MAX_ROWS * (2 ** COL_W);
   localparam int unsigned CMP_W = 10;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_ADV  = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_READ = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // Configuration registers.
   logic [ROWS_CFG_W-1:0] rows_in_use_ff;
   logic [COLS_CFG_W-1:0] columns_in_use_ff;

   // Control and latched item.
   logic [2:0]          state_ff, state_in;
   logic [2:0]          op_ff;
   logic [CHAR_W-1:0]   code_ff;
   logic [4:0]          rrow_ff;
   logic [6:0]          rcol_ff;
   logic                put_pend_ff;
   logic                read_hit_ff;
   logic [CHAR_W-1:0]   read_char_ff;

   // Cursor and per-row fill counts.
   logic [ROW_W-1:0]        row_ff;
   logic [CURSOR_COL_W-1:0] col_ff;
   logic [FILL_W-1:0]       fill_ff [MAX_ROWS];

   // Remainder unit.
   logic [NUM_W-1:0] div_num_ff;
   logic [NUM_W-1:0] div_rem_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic [NUM_W:0]   rem_shift;
   logic [NUM_W-1:0] rem_next;

   // Output register.
   logic                    rsp_valid_ff;
   logic [CHAR_W-1:0]       rsp_char_ff;
   logic [OUT_ROW_W-1:0]    rsp_row_ff;
   logic [CURSOR_COL_W-1:0] rsp_col_ff;

   // Cell store.
   logic [CHAR_W-1:0] cell_mem [DEPTH];
   logic [CHAR_W-1:0] mem_q;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CHAR_W-1:0] mem_wdata;

   logic                    req_accept;
   logic                    out_free;
   logic [NUM_W-1:0]        eff_rows;
   logic [CURSOR_COL_W-1:0] eff_cols;
   logic [NUM_W-1:0]        row_plus;
   logic                    row_fast;
   logic                    store_grows;
   logic                    read_in_grid;

   assign req_stall  = reset || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_char     = rsp_char_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;

   // Row and column counts clamped to what the store can hold.
   always_comb begin
      if (rows_in_use_ff == '0) begin
         eff_rows = NUM_W'(1);
      end else if (CMP_W'(rows_in_use_ff) > CMP_W'(MAX_ROWS)) begin
         eff_rows = NUM_W'(MAX_ROWS);
      end else begin
         eff_rows = NUM_W'(rows_in_use_ff);
      end
      if (columns_in_use_ff == '0) begin
         eff_cols = CURSOR_COL_W'(1);
      end else if (CMP_W'(columns_in_use_ff) > CMP_W'(ROW_CELLS - 1)) begin
         eff_cols = CURSOR_COL_W'(ROW_CELLS - 1);
      end else begin
         eff_cols = columns_in_use_ff;
      end
   end

   // The next row is row + 1 directly when that stays below the row count;
   // otherwise the remainder unit works it out.
   assign row_plus = NUM_W'(row_ff) + NUM_W'(1);
   assign row_fast = (row_plus < eff_rows);

   assign rem_shift = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, eff_rows}) ?
                      NUM_W'(rem_shift - {1'b0, eff_rows}) : NUM_W'(rem_shift);

   // A store at the cursor extends the row's fill count when it lands at its end.
   assign store_grows = (CMP_W'(col_ff) >= CMP_W'(fill_ff[row_ff]));

   assign read_in_grid = (CMP_W'(rrow_ff) < CMP_W'(MAX_ROWS)) &&
                         (CMP_W'(rcol_ff) < CMP_W'(ROW_CELLS));

   // Memory port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = NEWLINE_CODE;
      mem_waddr = {row_ff, COL_W'(col_ff)};
      mem_raddr = {ROW_W'(rrow_ff), COL_W'(rcol_ff)};
      case (state_ff)
         S_EXEC: begin
            mem_we = (op_ff == OP_MARK);
         end
         S_ADV: begin
            mem_we = 1'b1;
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = code_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= cell_mem[mem_raddr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (code_ff == NEWLINE_CODE || col_ff >= eff_cols) begin
                     state_in = S_ADV;
                  end else begin
                     state_in = S_PUT;
                  end
               end
               OP_LINE: state_in = S_ADV;
               OP_READ: state_in = S_READ;
               default: state_in = S_DONE;
            endcase
         end
         S_ADV: begin
            if (!row_fast) begin
               state_in = S_MOD;
            end else if (put_pend_ff) begin
               state_in = S_PUT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MOD: begin
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = put_pend_ff ? S_PUT : S_DONE;
            end
         end
         S_PUT:  state_in = S_DONE;
         S_READ: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff    <= ROWS_RESET;
         columns_in_use_ff <= COLUMNS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_ROWS) begin
            rows_in_use_ff <= ROWS_CFG_W'(csr_data);
         end else if (csr_index == CSR_COLUMNS) begin
            columns_in_use_ff <= COLS_CFG_W'(csr_data);
         end
      end
   end

   // Item payload latched at acceptance.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         code_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_column;
      end
   end

   // Cursor, fill counts, remainder unit and state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         put_pend_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_EXEC: begin
               case (op_ff)
                  OP_PUT: begin
                     put_pend_ff <= (code_ff != NEWLINE_CODE);
                  end
                  OP_LINE: begin
                     put_pend_ff <= 1'b0;
                  end
                  OP_CLEAR: begin
                     row_ff <= '0;
                     col_ff <= '0;
                     for (int i = 0; i < MAX_ROWS; i++) begin
                        fill_ff[i] <= '0;
                     end
                  end
                  OP_MARK: begin
                     if (store_grows) fill_ff[row_ff] <= FILL_W'(col_ff) + FILL_W'(1);
                  end
                  default: begin
                     put_pend_ff <= put_pend_ff;
                  end
               endcase
            end
            S_ADV: begin
               if (store_grows) fill_ff[row_ff] <= FILL_W'(col_ff) + FILL_W'(1);
               if (row_fast) begin
                  row_ff <= ROW_W'(row_plus);
                  col_ff <= '0;
                  fill_ff[ROW_W'(row_plus)] <= '0;
               end
            end
            S_MOD: begin
               if (div_cnt_ff == CNT_W'(1)) begin
                  row_ff <= ROW_W'(rem_next);
                  col_ff <= '0;
                  fill_ff[ROW_W'(rem_next)] <= '0;
               end
            end
            S_PUT: begin
               if (store_grows) fill_ff[row_ff] <= FILL_W'(col_ff) + FILL_W'(1);
               col_ff <= col_ff + CURSOR_COL_W'(1);
            end
            default: begin
               col_ff <= col_ff;
            end
         endcase
      end
   end

   // Remainder datapath: restoring, one dividend bit per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_ADV) begin
         div_num_ff <= row_plus;
         div_rem_ff <= '0;
         div_cnt_ff <= CNT_W'(NUM_W);
      end else if (state_ff == S_MOD) begin
         div_num_ff <= div_num_ff << 1;
         div_rem_ff <= rem_next;
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   // Read path: the fill count decides whether the stored word is current.
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         read_hit_ff  <= read_in_grid &&
                         (CMP_W'(fill_ff[ROW_W'(rrow_ff)]) > CMP_W'(rcol_ff));
         read_char_ff <= NUL_CODE;
      end else if (state_ff == S_READ) begin
         read_char_ff <= read_hit_ff ? mem_q : NUL_CODE;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_char_ff <= read_char_ff;
         rsp_row_ff  <= OUT_ROW_W'(row_ff);
         rsp_col_ff  <= col_ff;
      end
   end

   // The cursor column never reaches past the last cell of a row.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(col_ff) < CMP_W'(ROW_CELLS))
      else $error("cursor column beyond row");

   // The cursor row stays inside the store.
   a_row_in_store: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(row_ff) < CMP_W'(MAX_ROWS))
      else $error("cursor row beyond store");

   // Every cell before the cursor in its row is covered by the fill count,
   // so a store at the cursor never leaves a stale gap.
   a_fill_covers_cursor: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff[row_ff]) >= CMP_W'(col_ff))
      else $error("fill count behind cursor");

   // A result is only loaded from the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside completion");

   // No memory write happens while the block waits for an item.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("memory write while idle");

endmodule
